@@ src/mbrtu_pkg.sv @@
package mbrtu_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  FUNC_READ = 8'd3;
    localparam logic [15:0] LOW_MASK  = 16'h00FF;
    localparam int          FRAME_EXTRA = 5;

    localparam logic [7:0]  DEV_ADDR_RESET = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
    localparam logic [16:0] TICK_MAX       = 17'h1FFFF;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2
    } in_kind_t;

    typedef enum logic [1:0] {
        OUT_TX     = 2'd0,
        OUT_VALUE  = 2'd1,
        OUT_STATUS = 2'd2
    } out_kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_TIMEOUT = 2'd1,
        STAT_CRC     = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_DEV_ADDR = 1'd0,
        REG_TIMEOUT  = 1'd1
    } cfg_reg_t;

    // output sequencer
    typedef enum logic [3:0] {
        SEQ_IDLE   = 4'b0001,
        SEQ_FRAME  = 4'b0010,
        SEQ_DATA   = 4'b0100,
        SEQ_STATUS = 4'b1000
    } seq_state_t;

    // one byte through the reflected crc-16, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ src/modbus_rtu_register_read_master_unit.sv @@
// Modbus RTU read-holding-registers master. A start beat (tuser 0) sends the
// 8-byte request as eight result beats, one per cycle while the receiver is
// ready, with the crc built up as the bytes go out. Received bytes (tuser 1)
// and millisecond ticks (tuser 2) are taken one per cycle and give no result
// until the response completes or times out; then the values (one 32-bit beat
// per word pair, or the single register) follow one per cycle while the
// receiver is ready, closed by a status beat. Every input beat waits while
// results are still going out and is taken again in the cycle the final
// result beat leaves. This is set by the single result register: a start is
// held for its frame beats, a completed frame for its value beats and status,
// and a timeout or crc error for the status beat. All other beats pass at one
// per cycle. The crc of a received byte is checked in the cycle it arrives.
module modbus_rtu_register_read_master_unit #(
    parameter int MAX_WORDS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // register_address[15:0], word_count[19:16], rx_byte[27:20], zero fill
    input  logic [31:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tx_byte[7:0], value[39:8], status[41:40], zero fill
    output logic [47:0] m_tdata,
    // out_kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import mbrtu_pkg::*;

    // the word count field is 4 bits, so at most 15 words can be asked for
    localparam int EFF_MAX = (MAX_WORDS < 15) ? MAX_WORDS : 15;
    localparam int PAIRS   = (EFF_MAX / 2 > 0) ? EFF_MAX / 2 : 1;
    localparam int PW      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam logic [3:0] MAXW = 4'(EFF_MAX);

    logic [7:0]  dev_addr_reg;
    logic [15:0] timeout_reg;

    logic        waiting_reg, waiting_next;
    logic [3:0]  wc_reg, wc_next;
    logic [5:0]  bytes_reg, bytes_next;
    logic [16:0] ticks_reg, ticks_next;
    logic [15:0] run_crc_reg, run_crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [15:0] addr_reg, addr_next;

    seq_state_t  seq_reg, seq_next;
    logic [2:0]  beat_reg, beat_next;
    logic [15:0] tx_crc_reg, tx_crc_next;
    logic [PW-1:0] pair_reg, pair_next;
    status_t     stat_reg, stat_next;

    logic [31:0] val_mem [PAIRS];

    logic        s_acc, m_acc;
    in_kind_t    in_kind;
    logic [15:0] in_addr;
    logic [3:0]  in_wc, eff_wc;
    logic [7:0]  in_byte;
    logic [5:0]  nd;
    logic [5:0]  off;
    logic        data_wr;
    logic [15:0] rx_crc;
    logic        good;
    logic [17:0] limit;
    logic [16:0] ticks_inc;
    logic [7:0]  frame_byte;
    logic [PW-1:0] last_pair;
    logic [31:0] cur_val;

    assign in_kind = in_kind_t'(s_tuser);
    assign in_addr = s_tdata[15:0];
    assign in_wc   = s_tdata[19:16];
    assign in_byte = s_tdata[27:20];

    assign m_tvalid = (seq_reg != SEQ_IDLE);
    assign m_tlast  = (seq_reg == SEQ_STATUS) || ((seq_reg == SEQ_FRAME) && (beat_reg == 3'd7));
    assign s_tready = (seq_reg == SEQ_IDLE) || (m_tready && m_tlast);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;

    always_comb begin
        if (in_wc == 4'd0) begin
            eff_wc = 4'd1;
        end else if (in_wc > MAXW) begin
            eff_wc = MAXW;
        end else begin
            eff_wc = in_wc;
        end
        if (eff_wc > 4'd1) begin
            eff_wc = {eff_wc[3:1], 1'b0};
        end
    end

    assign nd        = {1'b0, wc_reg, 1'b0};
    assign off       = bytes_reg - 6'd3;
    assign data_wr   = s_acc && (in_kind == KIND_BYTE) && waiting_reg &&
                       (bytes_reg >= 6'd3) && (bytes_reg < nd + 6'd3);
    assign rx_crc    = crc_byte(run_crc_reg, in_byte);
    assign good      = ({8'h00, crc_lo_reg} == (run_crc_reg & LOW_MASK)) &&
                       (in_byte == run_crc_reg[15:8]);
    assign limit     = {2'b00, timeout_reg} + {13'd0, wc_reg, 1'b0} + 18'(FRAME_EXTRA);
    assign ticks_inc = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 17'd1;
    assign last_pair = (wc_reg == 4'd1) ? PW'(0) : PW'((wc_reg >> 1) - 4'd1);

    always_comb begin
        case (beat_reg)
            3'd0:    frame_byte = dev_addr_reg;
            3'd1:    frame_byte = FUNC_READ;
            3'd2:    frame_byte = addr_reg[15:8];
            3'd3:    frame_byte = addr_reg[7:0];
            3'd4:    frame_byte = 8'h00;
            3'd5:    frame_byte = {4'h0, wc_reg};
            3'd6:    frame_byte = tx_crc_reg[7:0];
            default: frame_byte = tx_crc_reg[15:8];
        endcase
    end

    // a single register leaves only its two bytes in the low half
    assign cur_val = (wc_reg == 4'd1) ? {16'h0000, val_mem[pair_reg][15:0]} : val_mem[pair_reg];

    always_comb begin
        m_tdata = '0;
        m_tuser = OUT_TX;
        case (seq_reg)
            SEQ_FRAME: begin
                m_tuser      = OUT_TX;
                m_tdata[7:0] = frame_byte;
            end
            SEQ_DATA: begin
                m_tuser       = OUT_VALUE;
                m_tdata[39:8] = cur_val;
            end
            SEQ_STATUS: begin
                m_tuser        = OUT_STATUS;
                m_tdata[41:40] = stat_reg;
            end
            default: begin
                m_tuser = OUT_TX;
            end
        endcase
    end

    always_comb begin
        waiting_next = waiting_reg;
        wc_next      = wc_reg;
        bytes_next   = bytes_reg;
        ticks_next   = ticks_reg;
        run_crc_next = run_crc_reg;
        crc_lo_next  = crc_lo_reg;
        addr_next    = addr_reg;
        seq_next     = seq_reg;
        beat_next    = beat_reg;
        tx_crc_next  = tx_crc_reg;
        pair_next    = pair_reg;
        stat_next    = stat_reg;

        if (m_acc) begin
            case (seq_reg)
                SEQ_FRAME: begin
                    beat_next = beat_reg + 3'd1;
                    if (beat_reg < 3'd6) begin
                        tx_crc_next = crc_byte(tx_crc_reg, frame_byte);
                    end
                    if (beat_reg == 3'd7) begin
                        seq_next = SEQ_IDLE;
                    end
                end
                SEQ_DATA: begin
                    if (pair_reg == last_pair) begin
                        seq_next  = SEQ_STATUS;
                        stat_next = STAT_OK;
                    end else begin
                        pair_next = pair_reg + PW'(1);
                    end
                end
                default: begin
                    seq_next = SEQ_IDLE;
                end
            endcase
        end

        if (s_acc) begin
            case (in_kind)
                KIND_START: begin
                    waiting_next = 1'b1;
                    wc_next      = eff_wc;
                    bytes_next   = '0;
                    ticks_next   = '0;
                    run_crc_next = CRC_INIT;
                    crc_lo_next  = '0;
                    addr_next    = in_addr;
                    seq_next     = SEQ_FRAME;
                    beat_next    = '0;
                    tx_crc_next  = CRC_INIT;
                end
                KIND_BYTE: begin
                    if (waiting_reg) begin
                        if (bytes_reg < nd + 6'd3) begin
                            run_crc_next = rx_crc;
                        end else if (bytes_reg == nd + 6'd3) begin
                            crc_lo_next = in_byte;
                        end
                        bytes_next = bytes_reg + 6'd1;
                        if (bytes_reg == nd + 6'd4) begin
                            waiting_next = 1'b0;
                            if (good) begin
                                seq_next  = SEQ_DATA;
                                pair_next = '0;
                            end else begin
                                seq_next  = SEQ_STATUS;
                                stat_next = STAT_CRC;
                            end
                        end
                    end
                end
                KIND_TICK: begin
                    if (waiting_reg) begin
                        ticks_next = ticks_inc;
                        if ({1'b0, ticks_inc} >= limit) begin
                            waiting_next = 1'b0;
                            seq_next     = SEQ_STATUS;
                            stat_next    = STAT_TIMEOUT;
                        end
                    end
                end
                default: begin
                    waiting_next = waiting_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= DEV_ADDR_RESET;
            timeout_reg  <= TIMEOUT_RESET;
            waiting_reg  <= 1'b0;
            wc_reg       <= '0;
            bytes_reg    <= '0;
            ticks_reg    <= '0;
            run_crc_reg  <= CRC_INIT;
            crc_lo_reg   <= '0;
            seq_reg      <= SEQ_IDLE;
            beat_reg     <= '0;
            pair_reg     <= '0;
            stat_reg     <= STAT_OK;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_DEV_ADDR: dev_addr_reg <= cfg_wdata[7:0];
                    default:      timeout_reg  <= cfg_wdata;
                endcase
            end
            waiting_reg <= waiting_next;
            wc_reg      <= wc_next;
            bytes_reg   <= bytes_next;
            ticks_reg   <= ticks_next;
            run_crc_reg <= run_crc_next;
            crc_lo_reg  <= crc_lo_next;
            seq_reg     <= seq_next;
            beat_reg    <= beat_next;
            pair_reg    <= pair_next;
            stat_reg    <= stat_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        tx_crc_reg <= tx_crc_next;
    end

    // data bytes land in their lane of the word-pair value
    always_ff @(posedge aclk) begin
        if (data_wr) begin
            case (off[1:0])
                2'd0:    val_mem[off[PW+1:2]][15:8]  <= in_byte;
                2'd1:    val_mem[off[PW+1:2]][7:0]   <= in_byte;
                2'd2:    val_mem[off[PW+1:2]][31:24] <= in_byte;
                default: val_mem[off[PW+1:2]][23:16] <= in_byte;
            endcase
        end
    end

    a_start_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (in_kind == KIND_START) |=> m_tvalid && (m_tuser == OUT_TX) && (beat_reg == 3'd0))
        else $error("start did not open a request frame");

    a_stall_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with nothing to deliver");

    a_rx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        waiting_reg |-> (bytes_reg < nd + 6'd5) && (wc_reg != 4'd0))
        else $error("receive count ran past the expected frame");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_acc && m_tlast |=> !m_tvalid || $past(s_acc))
        else $error("results appeared without an accepted item");

endmodule

@@ verif/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mbrtu_pkg::*;

    localparam int          MAX_WORDS   = 8;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          LONG_HOLD   = 200;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    typedef struct {
        out_kind_t   kind;
        logic [7:0]  tx;
        logic [31:0] value;
        status_t     status;
        logic        last;
    } reply_beat_t;

    // tracks one read transaction at a time and the beats it must produce
    class read_txn_scoreboard;
        logic [7:0]  dev_addr;
        logic [15:0] resp_base_ms;
        bit          waiting;
        int unsigned words;
        int unsigned rx_count;
        logic [16:0] ticks;
        logic [15:0] crc;
        logic [7:0]  crc_lo;
        logic [7:0]  payload [2*MAX_WORDS];
        reply_beat_t awaited_beats [$];
        int errors;
        int n_requests;
        int n_values;
        int n_ok;
        int n_timeouts;
        int n_crc_errors;

        function new();
            dev_addr     = DEV_ADDR_RESET;
            resp_base_ms = TIMEOUT_RESET;
            waiting      = 1'b0;
            words        = 0;
            rx_count     = 0;
            ticks        = '0;
            crc          = CRC_INIT;
            crc_lo       = '0;
        endfunction

        static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        static function int unsigned effective_words(logic [3:0] wc);
            int unsigned n;
            n = (wc == 4'd0) ? 1 : wc;
            if (n > MAX_WORDS) n = MAX_WORDS;
            if (n > 1) n = n - (n % 2);
            return n;
        endfunction

        function void push(out_kind_t k, logic [7:0] tx, logic [31:0] v, status_t s, bit l);
            reply_beat_t b;
            b.kind   = k;
            b.tx     = tx;
            b.value  = v;
            b.status = s;
            b.last   = l;
            awaited_beats.push_back(b);
        endfunction

        function void note_config(cfg_reg_t idx, logic [15:0] v);
            if (idx == REG_DEV_ADDR) begin
                dev_addr = v[7:0];
            end else begin
                resp_base_ms = v;
            end
        endfunction

        function void note_beat(logic [1:0] kind, logic [15:0] addr, logic [3:0] wc,
                                logic [7:0] rxb);
            logic [7:0]  frame [8];
            logic [15:0] c;
            int unsigned nd;
            int unsigned limit;
            int unsigned o;
            nd = 2 * words;
            case (kind)
                KIND_START: begin
                    words    = effective_words(wc);
                    frame[0] = dev_addr;
                    frame[1] = FUNC_READ;
                    frame[2] = addr[15:8];
                    frame[3] = addr[7:0];
                    frame[4] = 8'h00;
                    frame[5] = 8'(words);
                    c = CRC_INIT;
                    for (int i = 0; i < 6; i++) c = crc16_step(c, frame[i]);
                    frame[6] = c[7:0];
                    frame[7] = c[15:8];
                    for (int i = 0; i < 8; i++) push(OUT_TX, frame[i], '0, STAT_OK, i == 7);
                    waiting  = 1'b1;
                    rx_count = 0;
                    ticks    = '0;
                    crc      = CRC_INIT;
                    crc_lo   = '0;
                    n_requests++;
                end
                KIND_BYTE: begin
                    if (waiting) begin
                        if (rx_count < nd + 3) begin
                            crc = crc16_step(crc, rxb);
                            if (rx_count >= 3) payload[rx_count - 3] = rxb;
                        end else if (rx_count == nd + 3) begin
                            crc_lo = rxb;
                        end
                        rx_count++;
                        if (rx_count == nd + 5) begin
                            waiting = 1'b0;
                            if (crc_lo == crc[7:0] && rxb == crc[15:8]) begin
                                if (words == 1) begin
                                    push(OUT_VALUE, '0, {16'h0, payload[0], payload[1]},
                                         STAT_OK, 1'b0);
                                    n_values++;
                                end else begin
                                    for (int p = 0; p < words / 2; p++) begin
                                        o = 4 * p;
                                        // first word of the pair is the low half
                                        push(OUT_VALUE, '0, {payload[o+2], payload[o+3],
                                             payload[o], payload[o+1]}, STAT_OK, 1'b0);
                                        n_values++;
                                    end
                                end
                                push(OUT_STATUS, '0, '0, STAT_OK, 1'b1);
                                n_ok++;
                            end else begin
                                push(OUT_STATUS, '0, '0, STAT_CRC, 1'b1);
                                n_crc_errors++;
                            end
                        end
                    end
                end
                KIND_TICK: begin
                    if (waiting) begin
                        limit = resp_base_ms + nd + 5;
                        if (ticks != TICK_MAX) ticks++;
                        if (ticks >= limit && rx_count != nd + 5) begin
                            push(OUT_STATUS, '0, '0, STAT_TIMEOUT, 1'b1);
                            waiting = 1'b0;
                            n_timeouts++;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task flag(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 40)
                $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
        endtask

        task check_beat(logic [1:0] tuser, logic [47:0] tdata, logic tlast);
            reply_beat_t e;
            if (awaited_beats.size() == 0) begin
                flag("result beat with nothing awaited", {30'h0, tuser}, 32'h0);
                return;
            end
            e = awaited_beats.pop_front();
            if (tuser !== e.kind) flag("out_kind", {30'h0, tuser}, {30'h0, e.kind});
            if (tdata[7:0] !== e.tx) flag("tx_byte", {24'h0, tdata[7:0]}, {24'h0, e.tx});
            if (tdata[39:8] !== e.value) flag("value", tdata[39:8], e.value);
            if (tdata[41:40] !== e.status)
                flag("status", {30'h0, tdata[41:40]}, {30'h0, e.status});
            if (tlast !== e.last) flag("last", {31'h0, tlast}, {31'h0, e.last});
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_wdata;

    read_txn_scoreboard sb;
    bit src_gaps;
    bit sink_stalls;
    bit long_hold_req;
    int beats_total;
    int beats_live;
    int settings_used;
    int cycle_count;

    modbus_rtu_register_read_master_unit #(.MAX_WORDS(MAX_WORDS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // valid stays up across back-to-back beats bar random source gaps; callers that pause lower it
    task automatic offer_beat(logic [1:0] kind, logic [15:0] addr, logic [3:0] wc,
                              logic [7:0] rxb);
        bit live;
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tuser  <= kind;
        s_tdata  <= {4'h0, rxb, wc, addr};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        live = (kind == KIND_START) || ((kind == KIND_BYTE || kind == KIND_TICK) && sb.waiting);
        sb.note_beat(kind, addr, wc, rxb);
        beats_total++;
        if (live) beats_live++;
    endtask

    task automatic send_start(logic [15:0] addr, logic [3:0] wc);
        offer_beat(KIND_START, addr, wc, 8'($urandom));
    endtask

    task automatic send_byte(logic [7:0] b);
        offer_beat(KIND_BYTE, 16'($urandom), 4'($urandom), b);
    endtask

    task automatic send_tick();
        offer_beat(KIND_TICK, 16'($urandom), 4'($urandom), 8'($urandom));
    endtask

    // response frame for n words; only the first cut bytes go out
    task automatic send_reply(int unsigned n, int unsigned cut, bit spoil, int tick_pct);
        logic [7:0]  frame [2*MAX_WORDS+5];
        logic [15:0] c;
        int unsigned len;
        int unsigned pos;
        int          fill;
        len  = 2 * n + 5;
        fill = $urandom_range(0, 7);
        frame[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : sb.dev_addr;
        frame[1] = FUNC_READ;
        frame[2] = 8'(2 * n);
        for (int i = 3; i < len - 2; i++)
            frame[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
        c = CRC_INIT;
        for (int i = 0; i < len - 2; i++) c = read_txn_scoreboard::crc16_step(c, frame[i]);
        frame[len-2] = c[7:0];
        frame[len-1] = c[15:8];
        if (spoil) begin
            pos = $urandom_range(0, len - 1);
            frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 99) < tick_pct) send_tick();
            send_byte(frame[i]);
        end
    endtask

    // sender holds off until every awaited beat is back and the block has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.awaited_beats.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apply_settings(logic [15:0] dev_word, logic [15:0] timeout);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DEV_ADDR;
        cfg_wdata <= dev_word;
        @(posedge aclk);
        sb.note_config(REG_DEV_ADDR, dev_word);
        cfg_index <= REG_TIMEOUT;
        cfg_wdata <= timeout;
        @(posedge aclk);
        sb.note_config(REG_TIMEOUT, timeout);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(int quota);
        int          first;
        int          pick;
        logic [3:0]  wc;
        int unsigned n;
        logic [1:0]  noise_kind;
        first = beats_live;
        while (beats_live - first < quota) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0) begin
                wc = 4'($urandom_range(0, 15));
            end else begin
                wc = 4'(2 * $urandom_range(0, 4));
            end
            n = read_txn_scoreboard::effective_words(wc);
            if (pick < 60) begin
                send_start(16'($urandom), wc);
                send_reply(n, 2 * n + 5, $urandom_range(0, 9) == 0, 5);
            end else if (pick < 72 && sb.resp_base_ms <= 40) begin
                send_start(16'($urandom), wc);
                send_reply(n, $urandom_range(0, 2 * n + 4), 1'b0, 0);
                while (sb.waiting) send_tick();
            end else if (pick < 84) begin
                // left hanging, the next start abandons it
                send_start(16'($urandom), wc);
                send_reply(n, $urandom_range(0, 2 * n + 4), 1'b0, 10);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 2))
                        0: noise_kind = KIND_BYTE;
                        1: noise_kind = KIND_TICK;
                        default: noise_kind = KIND_UNUSED;
                    endcase
                    offer_beat(noise_kind, 16'($urandom), 4'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tuser, m_tdata, m_tlast);
    end

    // receiver: random stall bursts, one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        sb            = new();
        src_gaps      = 1'b1;
        sink_stalls   = 1'b1;
        long_hold_req = 1'b0;
        beats_total   = 0;
        beats_live    = 0;
        settings_used = 1;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: idle noise, saturation, abandon, good and bad crc
        offer_beat(KIND_BYTE, 16'h0000, 4'h0, 8'hFF);
        offer_beat(KIND_TICK, 16'hFFFF, 4'hF, 8'h00);
        offer_beat(KIND_UNUSED, 16'hFFFF, 4'hF, 8'hFF);
        send_start(16'hFFFF, 4'hF);
        send_start(16'h0000, 4'h0);
        send_reply(1, 7, 1'b0, 0);
        send_start(16'hA5C3, 4'd3);
        send_reply(2, 9, 1'b1, 0);
        settle();

        // zero base timeout; upper data bits of the address write are dropped
        apply_settings(16'hA500, 16'h0000);
        send_start(16'h8000, 4'd1);
        send_reply(1, 2, 1'b0, 0);
        while (sb.waiting) send_tick();
        send_byte(8'h5A);
        run_random(30);
        settle();

        apply_settings(16'd247, 16'hFFFF);
        long_hold_req = 1'b1;
        repeat (5) send_start(16'($urandom), 4'($urandom_range(0, 15)));
        run_random(30);
        settle();

        apply_settings(16'($urandom_range(0, 247)), 16'($urandom_range(0, 30)));
        run_random(30);
        settle();

        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        apply_settings(16'(8'h08 | (8'($urandom_range(0, 7)) << 4)), 16'($urandom));
        run_random(30);
        settle();
        repeat (20) @(posedge aclk);

        $display("covered %0d requests, %0d values, statuses ok %0d / timeout %0d / crc %0d",
                 sb.n_requests, sb.n_values, sb.n_ok, sb.n_timeouts, sb.n_crc_errors);
        $display("%0d input beats under %0d register settings, %0d mismatches",
                 beats_total, settings_used, sb.errors);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
